// ===== hdl/barrett_modular_multiplier_top_assert.svh =====
// assertion macros used by the checker file
`ifndef BARRETT_MODULAR_MULTIPLIER_TOP_ASSERT_SVH
`define BARRETT_MODULAR_MULTIPLIER_TOP_ASSERT_SVH

// property must hold at every clock edge outside reset
`define BMM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("barrett multiplier check failed");

// expression must never be true outside reset
`define BMM_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("barrett multiplier forbidden condition seen");

`endif

// ===== hdl/bmm_pkg.sv =====
`default_nettype none

package bmm_pkg;

  localparam int unsigned WordBits   = 64;
  localparam int unsigned HalfBits   = WordBits / 2;
  localparam int unsigned ModBits    = 62;
  localparam int unsigned CfgIdxBits = 2;

  // quotient estimate works on 2W x 2W in half-word limbs
  localparam int unsigned NumLimbs   = 4;
  localparam int unsigned NumCols    = 2 * NumLimbs - 2;
  localparam int unsigned ColBits    = 2 * HalfBits + 2;
  localparam int unsigned LoBits     = 4 * HalfBits + 3;
  localparam int unsigned HiBits     = 3 * HalfBits;
  localparam int unsigned SHiBits    = LoBits - 3 * HalfBits;
  localparam int unsigned QuotStages = 4;

  typedef logic [WordBits-1:0]   word_t;
  typedef logic [2*WordBits-1:0] dword_t;
  typedef logic [HalfBits-1:0]   half_t;
  typedef logic [2*HalfBits-1:0] prod_t;
  typedef logic [ModBits-1:0]    mod_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgModulus   = 2'd0,
    CfgRatioLow  = 2'd1,
    CfgRatioHigh = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KindMul    = 1'b0,
    KindReduce = 1'b1
  } kind_e;

endpackage

`default_nettype wire

// ===== hdl/bmm_quot.sv =====
`default_nettype none

// quotient estimate: bits [3W-1 : 2W] of value * ratio, four register stages
module bmm_quot (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  bmm_pkg::dword_t value_i,
  input  bmm_pkg::dword_t ratio_i,
  output logic            valid_o,
  output bmm_pkg::word_t  est_o
);

  bmm_pkg::half_t v_limb [bmm_pkg::NumLimbs];
  bmm_pkg::half_t r_limb [bmm_pkg::NumLimbs];
  bmm_pkg::prod_t pp_q   [bmm_pkg::NumLimbs][bmm_pkg::NumLimbs];

  logic [bmm_pkg::ColBits-1:0] col_d [bmm_pkg::NumCols];
  logic [bmm_pkg::ColBits-1:0] col_q [bmm_pkg::NumCols];

  logic [bmm_pkg::LoBits-1:0]  lo_sum;
  logic [bmm_pkg::SHiBits-1:0] s_hi_d, s_hi_q;
  logic [bmm_pkg::HiBits-1:0]  t_hi_d, t_hi_q;
  logic [bmm_pkg::HiBits-1:0]  top_sum;
  bmm_pkg::word_t              est_d, est_q;

  logic [bmm_pkg::QuotStages-1:0] vld_q;

  always_comb begin
    for (int k = 0; k < bmm_pkg::NumLimbs; k++) begin
      v_limb[k] = value_i[k*bmm_pkg::HalfBits +: bmm_pkg::HalfBits];
      r_limb[k] = ratio_i[k*bmm_pkg::HalfBits +: bmm_pkg::HalfBits];
    end
  end

  // partial products; the top limb pair only lands above the kept bits
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < bmm_pkg::NumLimbs; i++) begin
      for (int j = 0; j < bmm_pkg::NumLimbs; j++) begin
        if (i + j < bmm_pkg::NumCols) begin
          pp_q[i][j] <= bmm_pkg::prod_t'(v_limb[i]) * bmm_pkg::prod_t'(r_limb[j]);
        end else begin
          pp_q[i][j] <= '0;
        end
      end
    end
  end

  // column sums per limb weight
  always_comb begin
    for (int k = 0; k < bmm_pkg::NumCols; k++) begin
      col_d[k] = '0;
    end
    for (int i = 0; i < bmm_pkg::NumLimbs; i++) begin
      for (int j = 0; j < bmm_pkg::NumLimbs; j++) begin
        if (i + j < bmm_pkg::NumCols) begin
          col_d[i+j] = col_d[i+j] + bmm_pkg::ColBits'(pp_q[i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < bmm_pkg::NumCols; k++) begin
      col_q[k] <= col_d[k];
    end
  end

  // lower three columns only pass their carry-out above bit 3H
  always_comb begin
    lo_sum = bmm_pkg::LoBits'(col_q[0])
           + (bmm_pkg::LoBits'(col_q[1]) << bmm_pkg::HalfBits)
           + (bmm_pkg::LoBits'(col_q[2]) << (2 * bmm_pkg::HalfBits));
    s_hi_d = lo_sum[bmm_pkg::LoBits-1:3*bmm_pkg::HalfBits];
    t_hi_d = bmm_pkg::HiBits'(col_q[3])
           + (bmm_pkg::HiBits'(col_q[4]) << bmm_pkg::HalfBits)
           + (bmm_pkg::HiBits'(col_q[5]) << (2 * bmm_pkg::HalfBits));
  end

  always_ff @(posedge clk_i) begin
    s_hi_q <= s_hi_d;
    t_hi_q <= t_hi_d;
  end

  always_comb begin
    top_sum = t_hi_q + bmm_pkg::HiBits'(s_hi_q);
    est_d   = top_sum[bmm_pkg::HiBits-1:bmm_pkg::HalfBits];
  end

  always_ff @(posedge clk_i) begin
    est_q <= est_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[bmm_pkg::QuotStages-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[bmm_pkg::QuotStages-1];
  assign est_o   = est_q;

endmodule

`default_nettype wire

// ===== hdl/barrett_modular_multiplier_top.sv =====
// Barrett modular multiplier, 64-bit words, fully pipelined.
// Input: start_i with kind_i, operand_a_i, operand_b_i; busy_o stays low, so
// a transfer happens at every clock edge where start_i is high.
// kind 0 returns (a * b) mod q, kind 1 returns (b:a) mod q.
// Output: done_o is high for one cycle with residue_o; the receiver cannot
// stall, and results leave in the order the items came in.
// Throughput: one item per cycle, set by the pipeline of 32x32 multipliers
// (product, quotient estimate partial products, estimate times q).
// Stages: a*b partial products, 128-bit value, value*ratio partial products,
// column sums, column merge, estimate, est*q partial products, remainder,
// final conditional subtract.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 modulus, 1 ratio low word, 2 ratio high word); write only while idle.
// Reset clears the valid bits and sets modulus 2, ratio 0; items in flight
// at reset are dropped.
`default_nettype none

module barrett_modular_multiplier_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              kind_i,
  input  logic [bmm_pkg::WordBits-1:0]      operand_a_i,
  input  logic [bmm_pkg::WordBits-1:0]      operand_b_i,
  output logic                              done_o,
  output logic [bmm_pkg::WordBits-1:0]      residue_o,
  input  logic                              cfg_we_i,
  input  logic [bmm_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [bmm_pkg::WordBits-1:0]      cfg_data_i
);

  bmm_pkg::mod_t  modulus_q;
  bmm_pkg::word_t ratio_low_q, ratio_high_q;

  logic vld_a_q, vld_b_q, vld_g_q, vld_h_q, vld_i_q;

  // stage a
  bmm_pkg::prod_t ab00_q, ab01_q, ab10_q, ab11_q;
  logic           kind_q;
  bmm_pkg::word_t a_q, b_q;

  // stage b
  bmm_pkg::dword_t prod_ab;
  bmm_pkg::dword_t v_d, v_q;

  // estimate unit
  logic            est_vld;
  bmm_pkg::word_t  est;
  bmm_pkg::word_t  v0_q [bmm_pkg::QuotStages];

  // stage g
  bmm_pkg::prod_t eq00_q, eq01_q, eq10_q;
  bmm_pkg::word_t v0_g_q;

  // stage h, i
  bmm_pkg::word_t lo_eq, rem_d, rem_q;
  bmm_pkg::word_t q_ext, residue_d, residue_q;

  assign busy_o = 1'b0;
  assign q_ext  = bmm_pkg::word_t'(modulus_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q    <= bmm_pkg::mod_t'(2);
      ratio_low_q  <= '0;
      ratio_high_q <= '0;
    end else if (cfg_we_i) begin
      case (bmm_pkg::cfg_reg_e'(cfg_idx_i))
        bmm_pkg::CfgModulus:   modulus_q    <= cfg_data_i[bmm_pkg::ModBits-1:0];
        bmm_pkg::CfgRatioLow:  ratio_low_q  <= cfg_data_i;
        bmm_pkg::CfgRatioHigh: ratio_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_g_q <= 1'b0;
      vld_h_q <= 1'b0;
      vld_i_q <= 1'b0;
    end else begin
      vld_a_q <= start_i && !busy_o;
      vld_b_q <= vld_a_q;
      vld_g_q <= est_vld;
      vld_h_q <= vld_g_q;
      vld_i_q <= vld_h_q;
    end
  end

  // stage a: half-word partial products of a * b
  always_ff @(posedge clk_i) begin
    ab00_q <= bmm_pkg::prod_t'(operand_a_i[bmm_pkg::HalfBits-1:0])
            * bmm_pkg::prod_t'(operand_b_i[bmm_pkg::HalfBits-1:0]);
    ab01_q <= bmm_pkg::prod_t'(operand_a_i[bmm_pkg::HalfBits-1:0])
            * bmm_pkg::prod_t'(operand_b_i[bmm_pkg::WordBits-1:bmm_pkg::HalfBits]);
    ab10_q <= bmm_pkg::prod_t'(operand_a_i[bmm_pkg::WordBits-1:bmm_pkg::HalfBits])
            * bmm_pkg::prod_t'(operand_b_i[bmm_pkg::HalfBits-1:0]);
    ab11_q <= bmm_pkg::prod_t'(operand_a_i[bmm_pkg::WordBits-1:bmm_pkg::HalfBits])
            * bmm_pkg::prod_t'(operand_b_i[bmm_pkg::WordBits-1:bmm_pkg::HalfBits]);
    kind_q <= kind_i;
    a_q    <= operand_a_i;
    b_q    <= operand_b_i;
  end

  // stage b: full product or the given two-word value
  always_comb begin
    prod_ab = {ab11_q, ab00_q}
            + (bmm_pkg::dword_t'(ab01_q) << bmm_pkg::HalfBits)
            + (bmm_pkg::dword_t'(ab10_q) << bmm_pkg::HalfBits);
    if (bmm_pkg::kind_e'(kind_q) == bmm_pkg::KindMul) begin
      v_d = prod_ab;
    end else begin
      v_d = {b_q, a_q};
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  bmm_quot u_quot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_b_q),
    .value_i (v_q),
    .ratio_i ({ratio_high_q, ratio_low_q}),
    .valid_o (est_vld),
    .est_o   (est)
  );

  // low word of the value follows the estimate unit
  always_ff @(posedge clk_i) begin
    v0_q[0] <= v_q[bmm_pkg::WordBits-1:0];
    for (int k = 1; k < bmm_pkg::QuotStages; k++) begin
      v0_q[k] <= v0_q[k-1];
    end
  end

  // stage g: partial products for the low word of est * q
  always_ff @(posedge clk_i) begin
    eq00_q <= bmm_pkg::prod_t'(est[bmm_pkg::HalfBits-1:0])
            * bmm_pkg::prod_t'(q_ext[bmm_pkg::HalfBits-1:0]);
    eq01_q <= bmm_pkg::prod_t'(est[bmm_pkg::HalfBits-1:0])
            * bmm_pkg::prod_t'(q_ext[bmm_pkg::WordBits-1:bmm_pkg::HalfBits]);
    eq10_q <= bmm_pkg::prod_t'(est[bmm_pkg::WordBits-1:bmm_pkg::HalfBits])
            * bmm_pkg::prod_t'(q_ext[bmm_pkg::HalfBits-1:0]);
    v0_g_q <= v0_q[bmm_pkg::QuotStages-1];
  end

  // stage h: remainder, low word only
  always_comb begin
    lo_eq = eq00_q + (bmm_pkg::word_t'(eq01_q + eq10_q) << bmm_pkg::HalfBits);
    rem_d = v0_g_q - lo_eq;
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  // stage i: single conditional subtract
  always_comb begin
    if (rem_q >= q_ext) begin
      residue_d = rem_q - q_ext;
    end else begin
      residue_d = rem_q;
    end
  end

  always_ff @(posedge clk_i) begin
    residue_q <= residue_d;
  end

  assign done_o    = vld_i_q;
  assign residue_o = residue_q;

endmodule

`default_nettype wire

// ===== hdl/bmm_checker.sv =====
`default_nettype none

`include "barrett_modular_multiplier_top_assert.svh"

module bmm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           kind_i,
  input logic [bmm_pkg::WordBits-1:0]   operand_a_i,
  input logic [bmm_pkg::WordBits-1:0]   operand_b_i,
  input logic                           done_o,
  input logic [bmm_pkg::WordBits-1:0]   residue_o,
  input logic                           cfg_we_i,
  input logic [bmm_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input logic [bmm_pkg::WordBits-1:0]   cfg_data_i
);

  logic zero_in;

  // a zero value reduces to zero whatever the configuration
  assign zero_in = (kind_i == bmm_pkg::KindMul && operand_a_i == '0)
                || (kind_i == bmm_pkg::KindReduce && operand_a_i == '0
                    && operand_b_i == '0);

  `BMM_ASSERT(a_done_after_transfer, start_i && !busy_o |-> ##9 done_o)
  `BMM_ASSERT(a_done_has_transfer, done_o |-> $past(start_i && !busy_o, 9))
  `BMM_ASSERT(a_zero_gives_zero, start_i && !busy_o && zero_in |-> ##9 residue_o == '0)
  `BMM_ASSERT_NEVER(a_never_busy, busy_o)

endmodule

bind barrett_modular_multiplier_top bmm_checker u_bmm_checker (.*);

`default_nettype wire

// ===== tb/sv/barrett_modular_multiplier_top_tb.sv =====
`default_nettype none

module barrett_modular_multiplier_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmm_pkg::*;

  localparam int unsigned HalfPeriod    = 10;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned Latency       = 9;
  localparam int unsigned MaxCycles     = 400000;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned ItemsPerPhase = 183;
  localparam int unsigned RandomItems   = NumPhases * ItemsPerPhase;
  localparam int unsigned MaxReports    = 10;

  localparam logic [CfgIdxBits-1:0] CfgSpare = 2'd3;
  localparam word_t AllOnes  = '1;
  localparam word_t Alt5     = 64'h5555_5555_5555_5555;
  localparam word_t AltA     = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam mod_t  PrimeMod = 62'h3FFF_FFFF_FFFF_FFC7;
  localparam mod_t  MaxMod   = '1;

  typedef struct {
    kind_e       kind;
    word_t       a;
    word_t       b;
    int unsigned gap_pct;
  } mul_job_t;

  typedef struct {
    kind_e kind;
    word_t a;
    word_t b;
    word_t residue;
  } residue_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic kind_i = 1'b0;
  word_t operand_a_i = '0;
  word_t operand_b_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  word_t cfg_data_i = '0;
  logic busy_o;
  logic done_o;
  word_t residue_o;

  // shadow of the configuration registers
  mod_t  q_cfg = 62'd2;
  word_t ratio_lo_cfg = '0;
  word_t ratio_hi_cfg = '0;

  mul_job_t     pending_jobs[$];
  residue_exp_t residue_q[$];
  mul_job_t     cur_job;
  residue_exp_t fresh_exp;
  residue_exp_t head_exp;

  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned got_cnt = 0;
  int unsigned fault_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned rand_idx = 0;
  bit took = 1'b0;

  barrett_modular_multiplier_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .kind_i      (kind_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .done_o      (done_o),
    .residue_o   (residue_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  function automatic word_t rand64();
    return {$urandom, $urandom};
  endfunction

  // barrett estimate from the top partial products of value * ratio
  function automatic word_t barrett_residue(kind_e kind, word_t a, word_t b);
    dword_t v;
    dword_t p;
    word_t v0, v1, q, c2, acc, top, sum, est, rem;
    q = word_t'(q_cfg);
    if (kind == KindMul) v = dword_t'(a) * dword_t'(b);
    else v = {b, a};
    v0 = v[WordBits-1:0];
    v1 = v[2*WordBits-1:WordBits];
    p = dword_t'(v0) * dword_t'(ratio_lo_cfg);
    c2 = p[2*WordBits-1:WordBits];
    p = dword_t'(v0) * dword_t'(ratio_hi_cfg);
    acc = p[WordBits-1:0] + c2;
    top = p[2*WordBits-1:WordBits] + word_t'(acc < p[WordBits-1:0]);
    p = dword_t'(v1) * dword_t'(ratio_lo_cfg);
    sum = acc + p[WordBits-1:0];
    c2 = p[2*WordBits-1:WordBits] + word_t'(sum < acc);
    p = dword_t'(v1) * dword_t'(ratio_hi_cfg);
    est = p[WordBits-1:0] + top + c2;
    p = dword_t'(est) * dword_t'(q);
    rem = v0 - p[WordBits-1:0];
    if (rem >= q) rem = rem - q;
    return rem;
  endfunction

  function automatic void queue_job(kind_e kind, word_t a, word_t b, int unsigned gap);
    mul_job_t j;
    j.kind = kind;
    j.a = a;
    j.b = b;
    j.gap_pct = gap;
    pending_jobs.push_back(j);
    queued_cnt++;
  endfunction

  function automatic int unsigned gap_for(int unsigned idx);
    if (idx < RandomItems / 3) return 25;
    if (idx < 2 * RandomItems / 3) return 52;
    return 0;
  endfunction

  // mostly operands already reduced mod q, some extremes, some raw words
  function automatic void queue_random_job(int unsigned gap);
    kind_e kind;
    word_t a, b;
    int unsigned sel;
    kind = kind_e'($urandom_range(0, 1));
    a = rand64();
    b = rand64();
    sel = $urandom_range(0, 99);
    if (sel < 70 && q_cfg >= 2) begin
      b = b % word_t'(q_cfg);
      if (kind == KindMul) a = a % word_t'(q_cfg);
    end else if (sel < 80) begin
      a = $urandom_range(0, 1) ? AllOnes : '0;
      b = $urandom_range(0, 1) ? AllOnes : word_t'(q_cfg);
    end
    queue_job(kind, a, b, gap);
  endfunction

  task automatic set_reg(logic [CfgIdxBits-1:0] idx, word_t data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgModulus:   q_cfg = data[ModBits-1:0];
      CfgRatioLow:  ratio_lo_cfg = data;
      CfgRatioHigh: ratio_hi_cfg = data;
      default: ;
    endcase
  endtask

  task automatic load_modulus(word_t data, bit exact);
    logic [2*WordBits:0] num;
    dword_t ratio;
    num = '0;
    num[2*WordBits] = 1'b1;
    if (exact) ratio = dword_t'(num / data[ModBits-1:0]);
    else ratio = {rand64(), rand64()};
    set_reg(CfgModulus, data);
    set_reg(CfgRatioLow, ratio[WordBits-1:0]);
    set_reg(CfgRatioHigh, ratio[2*WordBits-1:WordBits]);
  endtask

  task automatic wait_idle();
    wait (accepted_cnt == queued_cnt && got_cnt == accepted_cnt);
  endtask

  // driver: new item or idle at each falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !took) begin
      // hold until the transfer happens
    end else if (pending_jobs.size() != 0 &&
                 $urandom_range(0, 99) >= pending_jobs[0].gap_pct) begin
      cur_job = pending_jobs.pop_front();
      start_i <= 1'b1;
      kind_i <= cur_job.kind;
      operand_a_i <= cur_job.a;
      operand_b_i <= cur_job.b;
    end else begin
      start_i <= 1'b0;
      kind_i <= 1'($urandom_range(0, 1));
      operand_a_i <= rand64();
      operand_b_i <= rand64();
    end
  end

  // monitor: record input transfers, then check results
  always @(posedge clk_i) begin
    took = 1'b0;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        fresh_exp.kind = kind_e'(kind_i);
        fresh_exp.a = operand_a_i;
        fresh_exp.b = operand_b_i;
        fresh_exp.residue = barrett_residue(kind_e'(kind_i), operand_a_i, operand_b_i);
        residue_q.push_back(fresh_exp);
        accepted_cnt++;
        took = 1'b1;
      end
      if (done_o) begin
        if (residue_q.size() == 0) begin
          if (fault_cnt < MaxReports)
            $display("unexpected result residue=%h", residue_o);
          fault_cnt++;
        end else begin
          head_exp = residue_q.pop_front();
          got_cnt++;
          if (residue_o !== head_exp.residue) begin
            if (fault_cnt < MaxReports)
              $display("mismatch kind=%0d a=%h b=%h expected=%h actual=%h",
                       head_exp.kind, head_exp.a, head_exp.b, head_exp.residue,
                       residue_o);
            fault_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MaxCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values: modulus 2, ratio 0
    queue_job(KindMul, AllOnes, AllOnes, 25);
    queue_job(KindMul, 64'd3, 64'd5, 25);
    queue_job(KindMul, '0, '0, 25);
    queue_job(KindReduce, AllOnes, AllOnes, 25);
    queue_job(KindReduce, 64'd1, '0, 25);
    queue_job(KindReduce, '0, AllOnes, 25);
    wait_idle();

    load_modulus(word_t'(PrimeMod), 1'b1);
    set_reg(CfgSpare, rand64());
    queue_job(KindMul, '0, '0, 25);
    queue_job(KindMul, AllOnes, AllOnes, 25);
    queue_job(KindMul, word_t'(PrimeMod) - 1, word_t'(PrimeMod) - 1, 25);
    queue_job(KindMul, word_t'(PrimeMod), 64'd1, 25);
    queue_job(KindMul, 64'd1, AllOnes, 25);
    queue_job(KindMul, Alt5, AltA, 25);
    queue_job(KindReduce, '0, '0, 25);
    // high word at or above q leaves the estimate short
    queue_job(KindReduce, AllOnes, AllOnes, 25);
    queue_job(KindReduce, AllOnes, word_t'(PrimeMod) - 1, 25);
    queue_job(KindReduce, '0, word_t'(PrimeMod), 25);
    queue_job(KindReduce, 64'd1, '0, 25);
    queue_job(KindReduce, word_t'(PrimeMod), '0, 25);
    queue_job(KindReduce, AltA, Alt5, 25);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: load_modulus(64'd2, 1'b1);
        1: load_modulus(64'd3, 1'b1);
        2: load_modulus(word_t'(MaxMod), 1'b1);
        3: load_modulus({2'b00, 2'b01, 60'(rand64() >> 4)} | 64'd1, 1'b1);
        4: load_modulus(word_t'($urandom_range(2, 65535)), 1'b1);
        5: load_modulus({2'b00, 62'(rand64() >> 2)} | 64'd2, 1'b1);
        // ratio that does not belong to q
        6: load_modulus({2'b00, 62'(rand64() >> 2)} | 64'd2, 1'b0);
        // degenerate moduli, upper data bits dropped by the register
        7: load_modulus({2'b11, 62'd0}, 1'b0);
        8: load_modulus(64'd1, 1'b0);
        default: load_modulus({2'b10, PrimeMod}, 1'b1);
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        queue_random_job(gap_for(rand_idx));
        rand_idx++;
      end
      wait_idle();
    end

    repeat (Latency + 4) @(posedge clk_i);
    if (fault_cnt == 0 && residue_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/bmm_pkg.sv
hdl/bmm_quot.sv
hdl/barrett_modular_multiplier_top.sv
hdl/bmm_checker.sv
tb/sv/barrett_modular_multiplier_top_tb.sv
